>>> src/rte_pkg.sv
`timescale 1ns / 1ps

package rte_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_ACTIVATE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ACTIVE   = 3'd4;

  localparam logic [7:0] REROUTE_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] old_dest;
    logic [31:0] new_dest;
    logic [15:0] lifetime;
    logic [7:0]  reroute_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] dest_out;
    logic        rerouted;
    logic [7:0]  reroute_out;
  } res_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic        hit;
    logic        hit_active;
    logic [31:0] hit_target;
    logic        free_seen;
  } scan_t;

  // table update broadcast to every cell at the end of a search
  typedef struct packed {
    logic insert_en;
    logic activate_en;
    logic tick_en;
  } commit_t;

endpackage

>>> src/rte_cell.sv
`timescale 1ns / 1ps

module rte_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  rte_pkg::scan_t   scan_i,
  output logic             go_o,
  output rte_pkg::scan_t   scan_o,
  input  logic [31:0]      key_i,
  input  logic [31:0]      target_i,
  input  logic [15:0]      lifetime_i,
  input  rte_pkg::commit_t commit_i
);

  logic        valid_q, valid_d;
  logic        active_q, active_d;
  logic [31:0] key_q;
  logic [31:0] target_q;
  logic [15:0] remaining_q;
  logic        go_q;
  rte_pkg::scan_t scan_q, scan_d;
  logic        own_match_q;
  logic        first_free_q;
  logic        match;
  logic        write_en;
  logic        expire;

  assign match    = valid_q && (key_q == key_i);
  assign write_en = commit_i.insert_en && first_free_q;
  assign expire   = commit_i.tick_en && valid_q && (remaining_q <= 16'd1);

  always_comb begin
    scan_d = scan_i;
    if (match && !scan_i.hit) begin
      scan_d.hit        = 1'b1;
      scan_d.hit_active = active_q;
      scan_d.hit_target = target_q;
    end
    scan_d.free_seen = scan_i.free_seen || !valid_q;
  end

  always_comb begin
    valid_d  = valid_q;
    active_d = active_q;
    if (write_en) begin
      valid_d  = 1'b1;
      active_d = 1'b0;
    end else if (expire) begin
      valid_d  = 1'b0;
      active_d = 1'b0;
    end else if (commit_i.activate_en && own_match_q) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
      go_q     <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= active_d;
      go_q     <= go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      scan_q       <= scan_d;
      own_match_q  <= match && !scan_i.hit;
      first_free_q <= !valid_q && !scan_i.free_seen;
    end
    if (write_en) begin
      key_q       <= key_i;
      target_q    <= target_i;
      remaining_q <= lifetime_i;
    end else if (commit_i.tick_en && valid_q && !expire) begin
      remaining_q <= remaining_q - 16'd1;
    end
  end

  assign go_o   = go_q;
  assign scan_o = scan_q;

endmodule

>>> src/reroute_table_with_expiry.sv
`timescale 1ns / 1ps

// channel   direction  signals              transfer when
// request   in         start, busy, req_i   start high and busy low at a rising edge
// result    out        done_o, res_o        done_o high; one cycle, cannot be held off
//
// one item at a time: a request holds the block from its transfer to the
// next possible transfer while the search token walks the row of cells one
// cell per cycle; the result shows in the cycle after the last cell
// reset clears every entry's valid and active flags and the control; no
// clearing pass, the table is usable in the first cycle after reset
// busy stays high from the transfer until the result is registered

module reroute_table_with_expiry #(
  parameter int ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rte_pkg::req_t   req_i,
  output logic            done_o,
  output rte_pkg::res_t   res_o
);

  // request held for the whole search, its fields are broadcast to the cells
  rte_pkg::req_t   req_q;
  logic            busy_q, busy_d;
  logic            launch_q;
  logic            done_q;
  rte_pkg::res_t   res_q, res_d;
  rte_pkg::commit_t commit;
  logic            accept;

  // token chain: index k feeds cell k, index ENTRIES is the row's end
  logic            go_chain   [ENTRIES+1];
  rte_pkg::scan_t  scan_chain [ENTRIES+1];
  logic            scan_done;
  rte_pkg::scan_t  scan_end;

  assign accept = start && !busy_q;

  assign go_chain[0]   = launch_q;
  assign scan_chain[0] = '0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    rte_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .go_i       (go_chain[k]),
      .scan_i     (scan_chain[k]),
      .go_o       (go_chain[k+1]),
      .scan_o     (scan_chain[k+1]),
      .key_i      (req_q.old_dest),
      .target_i   (req_q.new_dest),
      .lifetime_i (req_q.lifetime),
      .commit_i   (commit)
    );
  end

  assign scan_done = go_chain[ENTRIES];
  assign scan_end  = scan_chain[ENTRIES];

  // decide result and table update once the token leaves the last cell
  always_comb begin
    res_d  = '0;
    commit = '0;
    unique case (req_q.cmd)
      rte_pkg::CMD_INSERT: begin
        if (scan_end.hit) begin
          res_d.status = rte_pkg::ST_DUP;
        end else if (!scan_end.free_seen) begin
          res_d.status = rte_pkg::ST_FULL;
        end else begin
          commit.insert_en = scan_done;
        end
      end
      rte_pkg::CMD_ACTIVATE: begin
        if (!scan_end.hit) begin
          res_d.status = rte_pkg::ST_NOTFOUND;
        end else if (scan_end.hit_active) begin
          res_d.status = rte_pkg::ST_ACTIVE;
        end else begin
          commit.activate_en = scan_done;
        end
      end
      rte_pkg::CMD_LOOKUP: begin
        if (scan_end.hit && scan_end.hit_active) begin
          res_d.dest_out    = scan_end.hit_target;
          res_d.rerouted    = 1'b1;
          // saturating bump of the reroute count
          res_d.reroute_out = (req_q.reroute_in == rte_pkg::REROUTE_MAX) ?
                              rte_pkg::REROUTE_MAX : req_q.reroute_in + 8'd1;
        end else begin
          res_d.dest_out    = req_q.old_dest;
          res_d.reroute_out = req_q.reroute_in;
        end
      end
      rte_pkg::CMD_TICK: begin
        commit.tick_en = scan_done;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (scan_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      launch_q <= accept;
      done_q   <= scan_done;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (scan_done) begin
      res_q <= res_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> tb/sv/reroute_table_checker.sv
`timescale 1ns / 1ps

module reroute_table_checker #(
  parameter int ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  rte_pkg::req_t req_i,
  input  logic          done_o,
  input  rte_pkg::res_t res_o,
  output int            fail_count,
  output int            outstanding
);

  import rte_pkg::*;

  // shadow copy of the table
  logic [31:0] slot_key    [ENTRIES];
  logic [31:0] slot_target [ENTRIES];
  logic        slot_valid  [ENTRIES];
  logic        slot_active [ENTRIES];
  logic [15:0] slot_left   [ENTRIES];

  res_t expected_results[$];
  int   errors = 0;

  function automatic int find_key(logic [31:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // applies one command to the shadow table, returns the result it should give
  function automatic res_t apply_to_table(req_t r);
    res_t res;
    int   s;
    res = '0;
    res.status = ST_OK;
    case (r.cmd)
      CMD_INSERT: begin
        if (find_key(r.old_dest) >= 0) begin
          res.status = ST_DUP;
        end else begin
          s = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid[i]) s = i;
          end
          if (s < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_key[s]    = r.old_dest;
            slot_target[s] = r.new_dest;
            slot_valid[s]  = 1'b1;
            slot_active[s] = 1'b0;
            slot_left[s]   = r.lifetime;
          end
        end
      end
      CMD_ACTIVATE: begin
        s = find_key(r.old_dest);
        if (s < 0) res.status = ST_NOTFOUND;
        else if (slot_active[s]) res.status = ST_ACTIVE;
        else slot_active[s] = 1'b1;
      end
      CMD_LOOKUP: begin
        s = find_key(r.old_dest);
        if (s >= 0 && slot_active[s]) begin
          res.dest_out    = slot_target[s];
          res.rerouted    = 1'b1;
          res.reroute_out = (r.reroute_in == REROUTE_MAX) ? REROUTE_MAX
                                                          : r.reroute_in + 8'd1;
        end else begin
          res.dest_out    = r.old_dest;
          res.reroute_out = r.reroute_in;
        end
      end
      default: begin
        // tick: zero or one left means the entry expires now
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            if (slot_left[i] <= 16'd1) begin
              slot_valid[i]  = 1'b0;
              slot_active[i] = 1'b0;
            end else begin
              slot_left[i] = slot_left[i] - 16'd1;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]    = '0;
        slot_target[i] = '0;
        slot_valid[i]  = 1'b0;
        slot_active[i] = 1'b0;
        slot_left[i]   = '0;
      end
      expected_results.delete();
    end else begin
      // result first, so a stray result is not matched to a request of this edge
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request waiting");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(res_o.status));
          compare_field("dest_out", want.dest_out, res_o.dest_out);
          compare_field("rerouted", 32'(want.rerouted), 32'(res_o.rerouted));
          compare_field("reroute_out", 32'(want.reroute_out), 32'(res_o.reroute_out));
        end
      end
      if (start && !busy) expected_results.push_back(apply_to_table(req_i));
    end
    outstanding <= expected_results.size();
    fail_count  <= errors;
  end

endmodule

>>> tb/sv/reroute_table_with_expiry_test.sv
`timescale 1ns / 1ps

module reroute_table_with_expiry_test;

  import rte_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int POOL_SIZE  = 24;   // a bit more keys than slots so the table fills
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 52;
  localparam int QUIET_FROM = 10;   // phases from here on run without sender gaps

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  res_t res_o;
  int   fail_count;
  int   outstanding;

  logic [31:0] key_pool[POOL_SIZE];

  reroute_table_with_expiry #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // watches both channels, keeps the shadow table and counts mismatches
  reroute_table_checker #(
    .ENTRIES(ENTRIES)
  ) table_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // safety net: a hung handshake ends the run here
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] cmd, logic [31:0] old_dest,
                                    logic [31:0] new_dest, logic [15:0] lifetime,
                                    logic [7:0] reroute_in);
    req_t r;
    r.cmd        = cmd;
    r.old_dest   = old_dest;
    r.new_dest   = new_dest;
    r.lifetime   = lifetime;
    r.reroute_in = reroute_in;
    return r;
  endfunction

  // mostly keys from the pool so inserts, activates and lookups meet each other
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // short lifetimes dominate so ticks actually expire entries
  function automatic logic [15:0] pick_lifetime();
    int roll;
    roll = $urandom_range(99);
    if (roll < 78) return 16'($urandom_range(12, 1));
    if (roll < 90) return 16'($urandom_range(65534, 13));
    if (roll < 95) return 16'hFFFF;
    return 16'd0;  // out of range, acts like one tick
  endfunction

  // counts near saturation show up often
  function automatic logic [7:0] pick_reroute();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'hFF;
    if (roll < 20) return 8'hFE;
    if (roll < 25) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic req_t random_item(int tick_weight);
    req_t r;
    int   roll;
    r    = make_req(CMD_LOOKUP, pick_key(), $urandom, pick_lifetime(), pick_reroute());
    roll = $urandom_range(99);
    if (roll < tick_weight) begin
      r.cmd = CMD_TICK;
    end else begin
      roll = $urandom_range(99);
      if (roll < 35) r.cmd = CMD_INSERT;
      else if (roll < 60) r.cmd = CMD_ACTIVATE;
      else r.cmd = CMD_LOOKUP;
    end
    // some noise: odd destinations
    if ($urandom_range(99) < 5) r.new_dest = ($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF;
    return r;
  endfunction

  // raise start with the item and hold it until the transfer edge
  task automatic send_item(input req_t item);
    start <= 1'b1;
    req_i <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender stops until every result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    int tick_weight;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    // empty table: lookup misses, activate finds nothing
    send_item(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'd1, 8'hFF));
    send_item(make_req(CMD_ACTIVATE, 32'h1234_5678, 32'h0, 16'd1, 8'h00));
    // long-lived entry under the all-zero key, then a duplicate insert
    send_item(make_req(CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 8'h00));
    send_item(make_req(CMD_INSERT, 32'h0, 32'hA5A5_A5A5, 16'd3, 8'h00));
    // inactive entry does not reroute
    send_item(make_req(CMD_LOOKUP, 32'h0, 32'h0, 16'd1, 8'h10));
    send_item(make_req(CMD_ACTIVATE, 32'h0, 32'h0, 16'd1, 8'h00));
    send_item(make_req(CMD_ACTIVATE, 32'h0, 32'h0, 16'd1, 8'h00));
    // hit with the count already saturated
    send_item(make_req(CMD_LOOKUP, 32'h0, 32'h0, 16'd1, 8'hFF));
    // zero lifetime is gone after one tick
    send_item(make_req(CMD_INSERT, 32'hDEAD_BEEF, 32'h1, 16'd0, 8'h00));
    send_item(make_req(CMD_TICK, 32'h0, 32'h0, 16'd0, 8'h00));
    // fill every free slot, lowest free slot first
    for (int i = 0; i < ENTRIES - 1; i++) begin
      send_item(make_req(CMD_INSERT, 32'h8000_0000 + i, $urandom,
                         (i == 0) ? 16'd1 : 16'd2, 8'h00));
    end
    // full table: new key refused, duplicate check wins over full
    send_item(make_req(CMD_INSERT, 32'h7777_7777, 32'h2, 16'd5, 8'h00));
    send_item(make_req(CMD_INSERT, 32'h0, 32'h3, 16'd5, 8'h00));
    drain_results();

    // random part in phases with a changing tick rate; the no-tick phases fill
    // the table, the tick-heavy ones empty it
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: tick_weight = 0;
        1: tick_weight = 10;
        2: tick_weight = 20;
        default: tick_weight = 40;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_item(random_item(tick_weight));
        // gaps in bursts, except in one early phase and at the end of the run
        if (p < QUIET_FROM && p != 3 && $urandom_range(99) < 30) begin
          hold_off($urandom_range(9, 1));
        end
      end
      if (p % 3 == 2) drain_results();
    end

    // wait for the last result, then let the block settle
    drain_results();
    repeat (2 * ENTRIES + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rte_pkg.sv
src/rte_cell.sv
src/reroute_table_with_expiry.sv
tb/sv/reroute_table_checker.sv
tb/sv/reroute_table_with_expiry_test.sv
